/* hw/rtl/rmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // which component takes q/2: one of the axes, or w in the trace branch
  typedef enum logic [1:0] {
    SEL_X     = 2'd0,
    SEL_Y     = 2'd1,
    SEL_Z     = 2'd2,
    SEL_TRACE = 2'd3
  } sel_t;

  typedef struct packed {
    sel_t       sel;
    logic       inv;
    logic [2:0] neg;  // sign of each numerator
  } ctl_t;
endpackage
`default_nettype wire

/* hw/rtl/rmq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module rmq_front #(
  parameter int DW = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FB = rmq_pkg::FRAC_BITS_DEF,
  localparam int AW = ((DW > FB + 1) ? DW : FB + 1) + 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 v_i,
  output logic                      rdy_o,
  input  wire logic signed [DW-1:0] m00,
  input  wire logic signed [DW-1:0] m01,
  input  wire logic signed [DW-1:0] m02,
  input  wire logic signed [DW-1:0] m10,
  input  wire logic signed [DW-1:0] m11,
  input  wire logic signed [DW-1:0] m12,
  input  wire logic signed [DW-1:0] m20,
  input  wire logic signed [DW-1:0] m21,
  input  wire logic signed [DW-1:0] m22,
  output logic                      v_o,
  input  wire logic                 rdy_i,
  output logic [AW-2:0]             arg_o,
  output logic [3*(DW+1)-1:0]       mag_o,
  output rmq_pkg::ctl_t             ctl_o
);
  localparam logic signed [AW-1:0] ONE = AW'(1) << FB;

  logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [AW-1:0] trace, a;
  logic signed [AW-1:0] n [3];
  rmq_pkg::sel_t        isel;
  logic                 v_r;
  logic [AW-2:0]        arg_r, arg_nxt;
  logic [3*(DW+1)-1:0]  mag_r, mag_nxt;
  rmq_pkg::ctl_t        ctl_r, ctl_nxt;

  assign e00 = AW'(m00);
  assign e01 = AW'(m01);
  assign e02 = AW'(m02);
  assign e10 = AW'(m10);
  assign e11 = AW'(m11);
  assign e12 = AW'(m12);
  assign e20 = AW'(m20);
  assign e21 = AW'(m21);
  assign e22 = AW'(m22);
  assign trace = e00 + e11 + e22;

  always_comb begin
    isel = (e11 > e00) ? rmq_pkg::SEL_Y : rmq_pkg::SEL_X;
    if (e22 > ((isel == rmq_pkg::SEL_Y) ? e11 : e00)) isel = rmq_pkg::SEL_Z;
  end

  always_comb begin
    a = '0;
    n[0] = '0;
    n[1] = '0;
    n[2] = '0;
    ctl_nxt.inv = 1'b0;
    if (trace > 0) begin
      ctl_nxt.sel = rmq_pkg::SEL_TRACE;
      a    = trace + ONE;
      n[0] = e21 - e12;
      n[1] = e02 - e20;
      n[2] = e10 - e01;
    end else begin
      ctl_nxt.sel = isel;
      unique case (isel)
        rmq_pkg::SEL_X: begin
          a    = e00 - e11 - e22 + ONE;
          n[0] = e21 - e12;
          n[1] = e10 + e01;
          n[2] = e20 + e02;
        end
        rmq_pkg::SEL_Y: begin
          a    = e11 - e22 - e00 + ONE;
          n[0] = e02 - e20;
          n[1] = e21 + e12;
          n[2] = e01 + e10;
        end
        default: begin
          a    = e22 - e00 - e11 + ONE;
          n[0] = e10 - e01;
          n[1] = e02 + e20;
          n[2] = e12 + e21;
        end
      endcase
      ctl_nxt.inv = (a <= 0);
    end
    arg_nxt = a[AW-2:0];
    for (int l = 0; l < 3; l++) begin
      ctl_nxt.neg[l] = n[l][AW-1];
      mag_nxt[l*(DW+1) +: DW+1] = n[l][AW-1] ? (DW+1)'(0) - n[l][DW:0] : n[l][DW:0];
    end
  end

  assign rdy_o = !v_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      arg_r <= arg_nxt;
      mag_r <= mag_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign v_o   = v_r;
  assign arg_o = arg_r;
  assign mag_o = mag_r;
  assign ctl_o = ctl_r;
endmodule
`default_nettype wire

/* hw/rtl/rmq_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// one root bit per cell, restoring digit recurrence
module rmq_sqrt_cell #(
  parameter int QW = 16,
  parameter int PW = 51
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  output logic               rdy_o,
  input  wire logic [2*QW-1:0] n_i,
  input  wire logic [QW+1:0] rem_i,
  input  wire logic [QW-1:0] root_i,
  input  wire logic [PW-1:0] pay_i,
  input  wire rmq_pkg::ctl_t ctl_i,
  output logic               v_o,
  input  wire logic          rdy_i,
  output logic [2*QW-1:0]    n_o,
  output logic [QW+1:0]      rem_o,
  output logic [QW-1:0]      root_o,
  output logic [PW-1:0]      pay_o,
  output rmq_pkg::ctl_t      ctl_o
);
  logic              v_r;
  logic [2*QW-1:0]   n_r;
  logic [QW+1:0]     rem_r, rem_nxt, remc, trial;
  logic [QW-1:0]     root_r, root_nxt;
  logic [PW-1:0]     pay_r;
  rmq_pkg::ctl_t     ctl_r;

  always_comb begin
    remc  = {rem_i[QW-1:0], n_i[2*QW-1 -: 2]};
    trial = {root_i, 2'b01};
    if (remc >= trial) begin
      rem_nxt  = remc - trial;
      root_nxt = {root_i[QW-2:0], 1'b1};
    end else begin
      rem_nxt  = remc;
      root_nxt = {root_i[QW-2:0], 1'b0};
    end
  end

  assign rdy_o = !v_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      n_r    <= {n_i[2*QW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= pay_i;
      ctl_r  <= ctl_i;
    end
  end

  assign v_o    = v_r;
  assign n_o    = n_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;
  assign ctl_o  = ctl_r;
endmodule
`default_nettype wire

/* hw/rtl/rmq_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// one quotient bit per cell for three lanes sharing one divisor
module rmq_div_cell #(
  parameter int QW  = 16,
  parameter int DDW = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             v_i,
  output logic                  rdy_o,
  input  wire logic [QW:0]      d_i,
  input  wire logic [3*DDW-1:0] dvd_i,
  input  wire logic [3*(QW+2)-1:0] rem_i,
  input  wire logic [3*DDW-1:0] quo_i,
  input  wire logic [QW-1:0]    half_i,
  input  wire rmq_pkg::ctl_t    ctl_i,
  output logic                  v_o,
  input  wire logic             rdy_i,
  output logic [QW:0]           d_o,
  output logic [3*DDW-1:0]      dvd_o,
  output logic [3*(QW+2)-1:0]   rem_o,
  output logic [3*DDW-1:0]      quo_o,
  output logic [QW-1:0]         half_o,
  output rmq_pkg::ctl_t         ctl_o
);
  logic                  v_r;
  logic [QW:0]           d_r;
  logic [3*DDW-1:0]      dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [3*(QW+2)-1:0]   rem_r, rem_nxt;
  logic [QW-1:0]         half_r;
  rmq_pkg::ctl_t         ctl_r;
  logic [QW+1:0]         rc [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rc[l] = {rem_i[l*(QW+2) +: QW+1], dvd_i[l*DDW + DDW-1]};
      dvd_nxt[l*DDW +: DDW] = {dvd_i[l*DDW +: DDW-1], 1'b0};
      if (rc[l] >= {1'b0, d_i}) begin
        rem_nxt[l*(QW+2) +: QW+2] = rc[l] - {1'b0, d_i};
        quo_nxt[l*DDW +: DDW]     = {quo_i[l*DDW +: DDW-1], 1'b1};
      end else begin
        rem_nxt[l*(QW+2) +: QW+2] = rc[l];
        quo_nxt[l*DDW +: DDW]     = {quo_i[l*DDW +: DDW-1], 1'b0};
      end
    end
  end

  assign rdy_o = !v_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      d_r    <= d_i;
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      half_r <= half_i;
      ctl_r  <= ctl_i;
    end
  end

  assign v_o    = v_r;
  assign d_o    = d_r;
  assign dvd_o  = dvd_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign half_o = half_r;
  assign ctl_o  = ctl_r;
endmodule
`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Stages: one front stage, QW square-root cells, DDW divider cells, one output register.
// Throughput: one matrix per cycle while out_ready does not stall the output register;
//   every cell is a pipeline stage, stalls collapse bubbles.
// Reset: synchronous active-low rst_n clears all valid bits; the pipeline comes up empty.
module rotation_matrix_to_quaternion_unit #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_m00,
  input  wire logic signed [DATA_WIDTH-1:0] in_m01,
  input  wire logic signed [DATA_WIDTH-1:0] in_m02,
  input  wire logic signed [DATA_WIDTH-1:0] in_m10,
  input  wire logic signed [DATA_WIDTH-1:0] in_m11,
  input  wire logic signed [DATA_WIDTH-1:0] in_m12,
  input  wire logic signed [DATA_WIDTH-1:0] in_m20,
  input  wire logic signed [DATA_WIDTH-1:0] in_m21,
  input  wire logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_quat_w,
  output logic signed [DATA_WIDTH-1:0]      out_quat_x,
  output logic signed [DATA_WIDTH-1:0]      out_quat_y,
  output logic signed [DATA_WIDTH-1:0]      out_quat_z,
  output logic                              out_invalid
);
  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  // front arithmetic width; the square-root argument is AW-1 bits, unsigned
  localparam int AW  = ((DW > FB + 1) ? DW : FB + 1) + 3;
  localparam int NW  = AW - 1 + FB;         // radicand arg << FB
  localparam int QW  = (NW + 1) / 2;        // root bits = square-root cells
  localparam int MW  = DW + 1;              // numerator magnitude
  localparam int PW  = 3 * MW;
  localparam int DDW = ((MW + FB > QW) ? MW + FB : QW) + 1;  // dividend = divider cells
  localparam logic [QW+DW-1:0] SMAX = (QW+DW)'((1 << (DW - 1)) - 1);

  // ---------------------------------------------------------------- front
  logic            f_v;
  logic [AW-2:0]   f_arg;
  logic [PW-1:0]   f_mag;
  rmq_pkg::ctl_t   f_ctl;

  // ---------------------------------------------------------------- square-root chain
  logic              sq_v    [QW+1];
  logic              sq_rdy  [QW+1];
  logic [2*QW-1:0]   sq_n    [QW+1];
  logic [QW+1:0]     sq_rem  [QW+1];
  logic [QW-1:0]     sq_root [QW+1];
  logic [PW-1:0]     sq_pay  [QW+1];
  rmq_pkg::ctl_t     sq_ctl  [QW+1];

  // ---------------------------------------------------------------- divider chain
  logic                  dv_v    [DDW+1];
  logic                  dv_rdy  [DDW+1];
  logic [QW:0]           dv_d    [DDW+1];
  logic [3*DDW-1:0]      dv_dvd  [DDW+1];
  logic [3*(QW+2)-1:0]   dv_rem  [DDW+1];
  logic [3*DDW-1:0]      dv_quo  [DDW+1];
  logic [QW-1:0]         dv_half [DDW+1];
  rmq_pkg::ctl_t         dv_ctl  [DDW+1];

  logic [QW:0]     q_inc;

  // output register
  logic            out_valid_r;
  logic [DW-1:0]   w_r, x_r, y_r, z_r, w_nxt, x_nxt, y_nxt, z_nxt;
  logic            inv_r;
  logic [DW-1:0]   hs;
  logic [DW-1:0]   qs [3];

  rmq_front #(.DW(DW), .FB(FB)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (in_valid),
    .rdy_o (in_ready),
    .m00   (in_m00),
    .m01   (in_m01),
    .m02   (in_m02),
    .m10   (in_m10),
    .m11   (in_m11),
    .m12   (in_m12),
    .m20   (in_m20),
    .m21   (in_m21),
    .m22   (in_m22),
    .v_o   (f_v),
    .rdy_i (sq_rdy[0]),
    .arg_o (f_arg),
    .mag_o (f_mag),
    .ctl_o (f_ctl)
  );

  // radicand arg * 2^FB, zero padded to an even bit count
  assign sq_v[0]    = f_v;
  assign sq_n[0]    = (2*QW)'({f_arg, FB'(0)});
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = f_mag;
  assign sq_ctl[0]  = f_ctl;

  for (genvar g = 0; g < QW; g++) begin : g_sqrt
    rmq_sqrt_cell #(.QW(QW), .PW(PW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (sq_v[g]),
      .rdy_o  (sq_rdy[g]),
      .n_i    (sq_n[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .pay_i  (sq_pay[g]),
      .ctl_i  (sq_ctl[g]),
      .v_o    (sq_v[g+1]),
      .rdy_i  (sq_rdy[g+1]),
      .n_o    (sq_n[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .pay_o  (sq_pay[g+1]),
      .ctl_o  (sq_ctl[g+1])
    );
  end

  // divider setup: divisor 2q, dividend |n| * 2^FB + q (round half away from zero)
  assign sq_rdy[QW] = dv_rdy[0];
  assign q_inc      = {1'b0, sq_root[QW]} + (QW+1)'(1);
  assign dv_v[0]    = sq_v[QW];
  assign dv_d[0]    = {sq_root[QW], 1'b0};
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_half[0] = q_inc[QW:1];
  assign dv_ctl[0]  = sq_ctl[QW];
  for (genvar l = 0; l < 3; l++) begin : g_dvd
    assign dv_dvd[0][l*DDW +: DDW] = DDW'({sq_pay[QW][l*MW +: MW], FB'(0)})
                                   + DDW'(sq_root[QW]);
  end

  for (genvar g = 0; g < DDW; g++) begin : g_div
    rmq_div_cell #(.QW(QW), .DDW(DDW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (dv_v[g]),
      .rdy_o  (dv_rdy[g]),
      .d_i    (dv_d[g]),
      .dvd_i  (dv_dvd[g]),
      .rem_i  (dv_rem[g]),
      .quo_i  (dv_quo[g]),
      .half_i (dv_half[g]),
      .ctl_i  (dv_ctl[g]),
      .v_o    (dv_v[g+1]),
      .rdy_i  (dv_rdy[g+1]),
      .d_o    (dv_d[g+1]),
      .dvd_o  (dv_dvd[g+1]),
      .rem_o  (dv_rem[g+1]),
      .quo_o  (dv_quo[g+1]),
      .half_o (dv_half[g+1]),
      .ctl_o  (dv_ctl[g+1])
    );
  end

  // ---------------------------------------------------------------- saturation and placement
  // q/2 is never negative: clip at the positive limit only
  assign hs = ((QW+DW)'(dv_half[DDW]) > SMAX) ? SMAX[DW-1:0] : DW'(dv_half[DDW]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_ctl[DDW].neg[l]) begin
        // magnitude above 2^(DW-1) clips to the most negative code
        if ((|dv_quo[DDW][l*DDW + DW +: DDW-DW]) ||
            (dv_quo[DDW][l*DDW + DW-1] && (|dv_quo[DDW][l*DDW +: DW-1]))) begin
          qs[l] = {1'b1, (DW-1)'(0)};
        end else begin
          qs[l] = DW'(0) - dv_quo[DDW][l*DDW +: DW];
        end
      end else if (|dv_quo[DDW][l*DDW + DW-1 +: DDW-DW+1]) begin
        qs[l] = SMAX[DW-1:0];
      end else begin
        qs[l] = dv_quo[DDW][l*DDW +: DW];
      end
    end
  end

  // numerator 0 is w unless the trace branch was taken; 1 and 2 follow the axis cyclically
  always_comb begin
    w_nxt = qs[0];
    x_nxt = qs[1];
    y_nxt = qs[2];
    z_nxt = hs;
    unique case (dv_ctl[DDW].sel)
      rmq_pkg::SEL_TRACE: begin
        w_nxt = hs;
        x_nxt = qs[0];
        y_nxt = qs[1];
        z_nxt = qs[2];
      end
      rmq_pkg::SEL_X: begin
        x_nxt = hs;
        y_nxt = qs[1];
        z_nxt = qs[2];
      end
      rmq_pkg::SEL_Y: begin
        y_nxt = hs;
        z_nxt = qs[1];
        x_nxt = qs[2];
      end
      default: begin
        z_nxt = hs;
        x_nxt = qs[1];
        y_nxt = qs[2];
      end
    endcase
    // non-rotation input: zeros with the flag
    if (dv_ctl[DDW].inv) begin
      w_nxt = '0;
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end
  end

  // output register parts the divider chain from the consumer
  assign dv_rdy[DDW] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_rdy[DDW]) begin
      out_valid_r <= dv_v[DDW];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_rdy[DDW] && dv_v[DDW]) begin
      w_r   <= w_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      inv_r <= dv_ctl[DDW].inv;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_quat_w  = w_r;
  assign out_quat_x  = x_r;
  assign out_quat_y  = y_r;
  assign out_quat_z  = z_r;
  assign out_invalid = inv_r;
endmodule
`default_nettype wire

/* hw/rtl/rmq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module rmq_port_checker #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_WIDTH-1:0] out_quat_w,
  input wire logic [DATA_WIDTH-1:0] out_quat_x,
  input wire logic [DATA_WIDTH-1:0] out_quat_y,
  input wire logic [DATA_WIDTH-1:0] out_quat_z,
  input wire logic                  out_invalid
);
  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w) && $stable(out_quat_x)
      && $stable(out_quat_y) && $stable(out_quat_z) && $stable(out_invalid))
    else $error("result changed while stalled");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_quat_w == '0 && out_quat_x == '0
      && out_quat_y == '0 && out_quat_z == '0)
    else $error("invalid result with nonzero components");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty output stage frees the whole chain
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_port_checker #(.DATA_WIDTH(DATA_WIDTH))
  u_rmq_checker (.*);
`default_nettype wire
